### sv/gnb_pkg.sv
// ============================================================================
// gnb_pkg
// Shared types, constants and the first-quadrant trig table for the noise core.
// ============================================================================
package gnb_pkg;

    localparam int unsigned ROW_W   = 16;
    localparam int unsigned COL_W   = 16;
    localparam int unsigned NOISE_W = 16;
    localparam int unsigned SCALE_W = 24;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd3277;

    localparam logic [31:0] HASH_MUL_A = 32'h27d4eb2d;
    localparam logic [31:0] HASH_MUL_B = 32'h85ebca6b;

    // Angle decode: degree = h mod 360, split into quadrant and remainder
    localparam int unsigned ANGLE_STEPS = 360;
    localparam int unsigned QUAD_STEPS  = 90;

    typedef logic [15:0] t_q15u;   // first-quadrant magnitude 0..32768 (bit 15 = one)

    // round(32768*sin(r deg)) for r = 0..90; cos(r) = sin(90-r)
    function automatic logic [15:0] sin_q15(input logic [6:0] r);
        logic [15:0] v;
        case (r)
            7'd0: v = 16'd0;      7'd1: v = 16'd572;    7'd2: v = 16'd1144;
            7'd3: v = 16'd1715;   7'd4: v = 16'd2286;   7'd5: v = 16'd2856;
            7'd6: v = 16'd3425;   7'd7: v = 16'd3993;   7'd8: v = 16'd4560;
            7'd9: v = 16'd5126;   7'd10: v = 16'd5690;  7'd11: v = 16'd6252;
            7'd12: v = 16'd6813;  7'd13: v = 16'd7371;  7'd14: v = 16'd7927;
            7'd15: v = 16'd8481;  7'd16: v = 16'd9032;  7'd17: v = 16'd9580;
            7'd18: v = 16'd10126; 7'd19: v = 16'd10668; 7'd20: v = 16'd11207;
            7'd21: v = 16'd11743; 7'd22: v = 16'd12275; 7'd23: v = 16'd12803;
            7'd24: v = 16'd13328; 7'd25: v = 16'd13848; 7'd26: v = 16'd14365;
            7'd27: v = 16'd14876; 7'd28: v = 16'd15384; 7'd29: v = 16'd15886;
            7'd30: v = 16'd16384; 7'd31: v = 16'd16877; 7'd32: v = 16'd17364;
            7'd33: v = 16'd17847; 7'd34: v = 16'd18324; 7'd35: v = 16'd18795;
            7'd36: v = 16'd19261; 7'd37: v = 16'd19720; 7'd38: v = 16'd20174;
            7'd39: v = 16'd20622; 7'd40: v = 16'd21063; 7'd41: v = 16'd21498;
            7'd42: v = 16'd21926; 7'd43: v = 16'd22348; 7'd44: v = 16'd22763;
            7'd45: v = 16'd23170; 7'd46: v = 16'd23571; 7'd47: v = 16'd23965;
            7'd48: v = 16'd24351; 7'd49: v = 16'd24730; 7'd50: v = 16'd25102;
            7'd51: v = 16'd25466; 7'd52: v = 16'd25822; 7'd53: v = 16'd26170;
            7'd54: v = 16'd26510; 7'd55: v = 16'd26842; 7'd56: v = 16'd27166;
            7'd57: v = 16'd27482; 7'd58: v = 16'd27789; 7'd59: v = 16'd28088;
            7'd60: v = 16'd28378; 7'd61: v = 16'd28660; 7'd62: v = 16'd28932;
            7'd63: v = 16'd29197; 7'd64: v = 16'd29452; 7'd65: v = 16'd29698;
            7'd66: v = 16'd29935; 7'd67: v = 16'd30163; 7'd68: v = 16'd30382;
            7'd69: v = 16'd30592; 7'd70: v = 16'd30792; 7'd71: v = 16'd30983;
            7'd72: v = 16'd31164; 7'd73: v = 16'd31336; 7'd74: v = 16'd31499;
            7'd75: v = 16'd31651; 7'd76: v = 16'd31795; 7'd77: v = 16'd31928;
            7'd78: v = 16'd32052; 7'd79: v = 16'd32166; 7'd80: v = 16'd32270;
            7'd81: v = 16'd32365; 7'd82: v = 16'd32449; 7'd83: v = 16'd32524;
            7'd84: v = 16'd32588; 7'd85: v = 16'd32643; 7'd86: v = 16'd32688;
            7'd87: v = 16'd32723; 7'd88: v = 16'd32748; 7'd89: v = 16'd32763;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

    // Quadrant codes
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // Saturate a signed 17-bit value into Q1.15
    function automatic logic signed [15:0] sat_q15(input logic signed [16:0] v);
        logic signed [15:0] s;
        if (v > 17'sd32767) begin
            s = 16'sd32767;
        end else if (v < -17'sd32768) begin
            s = -16'sd32768;
        end else begin
            s = v[15:0];
        end
        return s;
    endfunction

endpackage

### sv/gnb_if.sv
// ============================================================================
// gnb_in_if / gnb_out_if
// Valid/ready channels carrying grid coordinates in and noise values out.
// ============================================================================
interface gnb_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] row;
    logic [15:0] col;
    modport source (output valid, output row, output col, input ready);
    modport sink   (input valid, input row, input col, output ready);
endinterface

interface gnb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] noise_value;
    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

### sv/gnb_corner.sv
// ============================================================================
// gnb_corner
// Pipelined corner evaluator: hash, angle decode, gradient lookup, dot product.
// Six register stages, advanced by a shared enable.
// ============================================================================
module gnb_corner
    import gnb_pkg::*;
#(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [COORD_BITS-1:0]        i_cx,
    input  logic [COORD_BITS-1:0]        i_cy,
    input  logic signed [FRAC_BITS+1:0]  i_dx,
    input  logic signed [FRAC_BITS+1:0]  i_dy,
    output logic signed [FRAC_BITS+2:0]  o_val
);

    localparam int unsigned DW = FRAC_BITS + 2;

    // Stage A: x xor y*A
    logic [31:0] r_ha;
    logic signed [DW-1:0] r_dxa, r_dya;
    // Stage B: h ^= h>>15, h*B
    logic [31:0] r_hb;
    logic signed [DW-1:0] r_dxb, r_dyb;
    // Stage C: h ^= h>>13, quotient estimate h/360 (via reciprocal)
    logic [31:0] r_hc;
    logic [23:0] r_quo;
    logic signed [DW-1:0] r_dxq, r_dyq;
    // Stage D: remainder fix -> degree
    logic [8:0] r_deg;
    logic signed [DW-1:0] r_dxc, r_dyc;
    // Stage E: gradient components
    logic signed [15:0] r_gx, r_gy;
    logic signed [DW-1:0] r_dxd, r_dyd;
    // Stage F: products
    logic signed [DW+16:0] r_px, r_py;

    logic [31:0] n_ha, hb1, n_hb, hc;
    logic [63:0] qprod;
    logic [32:0] qm;
    logic [32:0] rem;
    logic [8:0]  n_deg;
    logic [1:0]  quad;
    logic [6:0]  rr;
    logic [15:0] s_m, c_m;
    logic signed [16:0] cxv, syv;

    assign n_ha = 32'(i_cx) ^ (32'(i_cy) * HASH_MUL_A);
    assign hb1  = r_ha ^ (r_ha >> 15);
    assign n_hb = hb1 * HASH_MUL_B;
    assign hc   = r_hb ^ (r_hb >> 13);

    // h mod 360 by reciprocal: quo = floor(h*ceil(2^40/360) >> 40), then one fix
    assign qprod = 64'(hc) * 64'd3054198967;
    assign qm    = 33'(r_quo) * 33'(ANGLE_STEPS);
    assign rem   = 33'(r_hc) - qm;
    always_comb begin
        if (rem[32]) begin
            n_deg = 9'(rem + 33'(ANGLE_STEPS));
        end else if (rem >= 33'(ANGLE_STEPS)) begin
            n_deg = 9'(rem - 33'(ANGLE_STEPS));
        end else begin
            n_deg = 9'(rem);
        end
    end

    // Quadrant split of the degree
    always_comb begin
        if (r_deg >= 9'd270) begin
            quad = QUAD_3; rr = 7'(r_deg - 9'd270);
        end else if (r_deg >= 9'd180) begin
            quad = QUAD_2; rr = 7'(r_deg - 9'd180);
        end else if (r_deg >= 9'd90) begin
            quad = QUAD_1; rr = 7'(r_deg - 9'd90);
        end else begin
            quad = QUAD_0; rr = 7'(r_deg);
        end
        s_m = sin_q15(rr);
        c_m = sin_q15(7'(7'd90 - rr));
        case (t_quad'(quad))
            QUAD_0:  begin cxv =  17'(c_m); syv =  17'(s_m); end
            QUAD_1:  begin cxv = -17'(s_m); syv =  17'(c_m); end
            QUAD_2:  begin cxv = -17'(c_m); syv = -17'(s_m); end
            default: begin cxv =  17'(s_m); syv = -17'(c_m); end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ha  <= n_ha;  r_dxa <= i_dx;  r_dya <= i_dy;
            r_hb  <= n_hb;  r_dxb <= r_dxa; r_dyb <= r_dya;
            r_hc  <= hc;    r_quo <= qprod[63:40];
            r_dxq <= r_dxb; r_dyq <= r_dyb;
            r_deg <= n_deg; r_dxc <= r_dxq; r_dyc <= r_dyq;
            r_gx  <= sat_q15(cxv); r_gy <= sat_q15(syv);
            r_dxd <= r_dxc; r_dyd <= r_dyc;
            r_px  <= (DW+17)'(r_gx * r_dxd);
            r_py  <= (DW+17)'(r_gy * r_dyd);
        end
    end

    // (dot + 2^(15+F)) rounded half up by 16
    logic signed [DW+17:0] dot;
    assign dot   = (DW+18)'(r_px) + (DW+18)'(r_py) + ((DW+18)'(1) << (15 + FRAC_BITS))
                 + (DW+18)'(32768);
    assign o_val = (DW+1)'(dot >>> 16);

endmodule

### sv/gradient_noise_bilinear_core.sv
// ============================================================================
// gradient_noise_bilinear_core
// 2D gradient noise with bilinear blending, one sample per transfer.
// ============================================================================
// Throughput: one item per cycle unless the output stalls; the whole pipeline advances on one enable,
// and the output register frees whenever the sink takes its transfer.
// Reset: synchronous active-low; clears valid bits and loads scale = 3277.
// Payload registers are not reset.
module gradient_noise_bilinear_core
    import gnb_pkg::*;
#(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SCALE_W-1:0]  i_cfg_wdata,
    gnb_in_if.sink              in_ch,
    gnb_out_if.source           out_ch
);

    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned DW = F + 2;
    localparam int unsigned VW = F + 3;
    localparam int unsigned NS = 13;

    logic [SCALE_W-1:0] r_scale;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    // Pipeline enable: advance unless the last stage is full and not taken
    logic [NS-1:0] r_vld;
    logic en;
    assign en          = !r_vld[NS-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], in_ch.valid};
        end
    end

    // Stage 1: products with scale
    logic [39:0] r_px, r_py;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px <= 40'(in_ch.col) * 40'(r_scale);
            r_py <= 40'(in_ch.row) * 40'(r_scale);
        end
    end

    // Split into cell and fraction
    logic [COORD_BITS-1:0] x0, y0, x1, y1;
    logic [F-1:0] fx, fy;
    assign x0 = COORD_BITS'(r_px[39:16]);
    assign y0 = COORD_BITS'(r_py[39:16]);
    assign x1 = x0 + COORD_BITS'(1);
    assign y1 = y0 + COORD_BITS'(1);
    generate
        if (F >= 16) begin : g_fw
            assign fx = F'({r_px[15:0]} << (F - 16));
            assign fy = F'({r_py[15:0]} << (F - 16));
        end else begin : g_fn
            assign fx = F'(r_px[15:0] >> (16 - F));
            assign fy = F'(r_py[15:0] >> (16 - F));
        end
    endgenerate

    logic signed [DW-1:0] dx0, dy0, dx1, dy1;
    assign dx0 = DW'(fx);
    assign dy0 = DW'(fy);
    assign dx1 = DW'(fx) - (DW'(1) << F);
    assign dy1 = DW'(fy) - (DW'(1) << F);

    // Four corner pipelines, 6 stages each (stages 2..7)
    logic signed [VW-1:0] f00, f10, f01, f11;
    gnb_corner #(.COORD_BITS(COORD_BITS), .FRAC_BITS(F)) u_c00
        (.i_clk, .i_en(en), .i_cx(x0), .i_cy(y0), .i_dx(dx0), .i_dy(dy0), .o_val(f00));
    gnb_corner #(.COORD_BITS(COORD_BITS), .FRAC_BITS(F)) u_c10
        (.i_clk, .i_en(en), .i_cx(x1), .i_cy(y0), .i_dx(dx1), .i_dy(dy0), .o_val(f10));
    gnb_corner #(.COORD_BITS(COORD_BITS), .FRAC_BITS(F)) u_c01
        (.i_clk, .i_en(en), .i_cx(x0), .i_cy(y1), .i_dx(dx0), .i_dy(dy1), .o_val(f01));
    gnb_corner #(.COORD_BITS(COORD_BITS), .FRAC_BITS(F)) u_c11
        (.i_clk, .i_en(en), .i_cx(x1), .i_cy(y1), .i_dx(dx1), .i_dy(dy1), .o_val(f11));

    // Fraction delay line to line up with corner outputs
    logic [F-1:0] r_fxd [6];
    logic [F-1:0] r_fyd [6];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fxd[0] <= fx; r_fyd[0] <= fy;
            for (int k = 1; k < 6; k++) begin
                r_fxd[k] <= r_fxd[k-1]; r_fyd[k] <= r_fyd[k-1];
            end
        end
    end

    // Stage 8: register corners; stage 9: x-blend products
    localparam int unsigned PW = VW + F + 2;
    logic signed [VW-1:0] r_f00, r_f10, r_f01, r_f11;
    logic [F-1:0] r_fx7, r_fy7, r_fy8, r_fy9;
    logic signed [PW-1:0] r_pa, r_pb, r_pv;
    logic signed [VW-1:0] r_a8, r_b8, r_a9, r_b9, r_a10;
    logic signed [VW:0]   r_v11;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f00 <= f00; r_f10 <= f10; r_f01 <= f01; r_f11 <= f11;
            r_fx7 <= r_fxd[5]; r_fy7 <= r_fyd[5];
            // stage 9
            r_pa <= PW'((r_f10 - r_f00) * $signed({1'b0, r_fx7}));
            r_pb <= PW'((r_f11 - r_f01) * $signed({1'b0, r_fx7}));
            r_a8 <= r_f00; r_b8 <= r_f01; r_fy8 <= r_fy7;
            // stage 10: round and add
            r_a9 <= VW'(r_a8 + VW'((r_pa + (PW'(1) << (F - 1))) >>> F));
            r_b9 <= VW'(r_b8 + VW'((r_pb + (PW'(1) << (F - 1))) >>> F));
            r_fy9 <= r_fy8;
            // stage 11: y-blend product
            r_pv  <= PW'((r_b9 - r_a9) * $signed({1'b0, r_fy9}));
            r_a10 <= r_a9;
            // stage 12: round and add
            r_v11 <= (VW+1)'(r_a10) + (VW+1)'((r_pv + (PW'(1) << (F - 1))) >>> F);
        end
    end

    // Stage 13: convert to Q0.16 and saturate
    logic signed [VW+16:0] v16;
    logic [NOISE_W-1:0] r_out;
    generate
        if (F > 16) begin : g_dn
            assign v16 = (VW+17)'((r_v11 + (VW+1)'(1 << (F - 17))) >>> (F - 16));
        end else begin : g_up
            assign v16 = (VW+17)'(r_v11) <<< (16 - F);
        end
    endgenerate
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (v16 < 0) begin
                r_out <= '0;
            end else if (v16 > (VW+17)'(65535)) begin
                r_out <= 16'hffff;
            end else begin
                r_out <= v16[15:0];
            end
        end
    end

    assign out_ch.valid       = r_vld[NS-1];
    assign out_ch.noise_value = r_out;

    // A stalled result must hold
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.noise_value))
        else $error("result changed while stalled");
    // Input is refused only while output is stalled
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ch.ready |-> out_ch.valid && !out_ch.ready)
        else $error("input blocked without a stall");
    // Occupancy never grows during a stall
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved during stall");

endmodule
